// ===== hw/rtl/smm_pkg.sv =====
// Package for the square matrix multiply unit.
// Holds data widths, register map, state encoding and the lane control struct.
// No dependencies.
package smm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SIZE_W  = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MATRIX_SIZE
  } reg_idx_e;

  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } state_e;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd;
    logic active;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/smm_in_if.sv =====
// Input channel of the square matrix multiply unit: one element of each matrix.
// Depends on smm_pkg.
interface smm_in_if;
  import smm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] a_elem;
  logic signed [DATA_W-1:0] b_elem;

  modport source (output valid, output a_elem, output b_elem, input ready);
  modport sink   (input valid, input a_elem, input b_elem, output ready);

endinterface

// ===== hw/rtl/smm_out_if.sv =====
// Output channel of the square matrix multiply unit: one product element.
// Depends on smm_pkg.
interface smm_out_if;
  import smm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product_value;
  logic                     last_of_run;

  modport source (output valid, output product_value, output last_of_run, input ready);
  modport sink   (input valid, input product_value, input last_of_run, output ready);

endinterface

// ===== hw/rtl/smm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/smm_lane.sv =====
// One multiply lane: column k of the first matrix, row k of the second, and
// a registered product. Depends on smm_pkg and smm_ram.
module smm_lane #(
  parameter int unsigned MAX_SIZE = 8
) (
  input  logic                         clk_i,
  input  smm_pkg::lane_ctl_t           ctl_i,
  input  logic [$clog2(MAX_SIZE)-1:0]  wr_addr_a_i,
  input  logic [$clog2(MAX_SIZE)-1:0]  wr_addr_b_i,
  input  logic [smm_pkg::DATA_W-1:0]   wr_data_a_i,
  input  logic [smm_pkg::DATA_W-1:0]   wr_data_b_i,
  input  logic [$clog2(MAX_SIZE)-1:0]  rd_addr_a_i,
  input  logic [$clog2(MAX_SIZE)-1:0]  rd_addr_b_i,
  output logic [smm_pkg::DATA_W-1:0]   prod_o
);
  import smm_pkg::*;

  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic [DATA_W-1:0] prod_q;

  smm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_a),
    .waddr_i (wr_addr_a_i),
    .wdata_i (wr_data_a_i),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr_a_i),
    .rdata_o (rd_a)
  );

  smm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_b),
    .waddr_i (wr_addr_b_i),
    .wdata_i (wr_data_b_i),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr_b_i),
    .rdata_o (rd_b)
  );

  // Lanes beyond the matrix size contribute zero.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      prod_q <= ctl_i.active ? DATA_W'(rd_a * rd_b) : '0;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/smm_merge.sv =====
// Registered adder tree that sums the lane products into one dot product.
// Depends on smm_pkg.
module smm_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic                       last_i,
  input  logic [smm_pkg::DATA_W-1:0] val_i [LANES],
  output logic [smm_pkg::DATA_W-1:0] sum_o,
  output logic                       valid_o,
  output logic                       last_o
);
  import smm_pkg::*;

  localparam int unsigned LEVELS = $clog2(LANES);
  localparam int unsigned PAD    = 1 << LEVELS;

  logic [DATA_W-1:0] leaf [PAD];
  logic [DATA_W-1:0] node_q [1:LEVELS][PAD];
  logic [LEVELS:1]   vld_q;
  logic [LEVELS:1]   lst_q;

  for (genvar m = 0; m < PAD; m++) begin : g_leaf
    if (m < LANES) begin : g_used
      assign leaf[m] = val_i[m];
    end else begin : g_pad
      assign leaf[m] = '0;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar m = 0; m < (PAD >> l); m++) begin : g_node
      if (l == 1) begin : g_first
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            node_q[l][m] <= leaf[2*m] + leaf[2*m+1];
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            node_q[l][m] <= node_q[l-1][2*m] + node_q[l-1][2*m+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      lst_q <= '0;
    end else if (en_i) begin
      vld_q[1] <= valid_i;
      lst_q[1] <= last_i;
      for (int l = 2; l <= LEVELS; l++) begin
        vld_q[l] <= vld_q[l-1];
        lst_q[l] <= lst_q[l-1];
      end
    end
  end

  assign sum_o   = node_q[LEVELS][0];
  assign valid_o = vld_q[LEVELS];
  assign last_o  = lst_q[LEVELS];

endmodule

// ===== hw/rtl/square_matrix_multiply_unit.sv =====
// Square matrix multiply unit: multiplies two signed n x n matrices, n from 1 to MAX_SIZE.
// Depends on smm_pkg, smm_in_if, smm_out_if, smm_lane and smm_merge.
//
// Load n*n items (one element of each matrix, row-major) at one item per cycle;
// the block then emits the n*n product elements in row-major order, one per
// cycle while the output is taken, through the RAM read, lane product, adder
// tree and output registers, and marks the last. Input is not taken while a
// product is being emitted, so the next run cannot be loaded until the last
// product of this run has been taken. MAX_SIZE lanes, each with its own
// multiplier, form one dot product per cycle while the output is taken, and a
// registered adder tree merges them. Sums wrap modulo 2^32. A matrix_size of 0
// acts as 1, above MAX_SIZE as MAX_SIZE; writing it restarts loading.
module square_matrix_multiply_unit #(
  parameter int unsigned MAX_SIZE = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  smm_in_if.sink                      in_i,
  smm_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smm_pkg::PADDR_W-1:0] paddr,
  input  logic [smm_pkg::PDATA_W-1:0] pwdata,
  output logic [smm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import smm_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SIZE);

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] matrix_size_q;
  logic [IDX_W-1:0]  nm1;
  logic [IDX_W-1:0]  row_q, col_q;
  logic [IDX_W-1:0]  oi_q, oj_q;
  logic              issuing_q;
  logic              v1_q, l1_q, v2_q, l2_q;
  logic              out_valid_q, out_last_q;
  logic [DATA_W-1:0] out_data_q;
  logic              cfg_we, in_acc, out_acc, adv, issue, load_done, issue_last;
  lane_ctl_t         lane_ctl [MAX_SIZE];
  logic [DATA_W-1:0] lane_prod [MAX_SIZE];
  logic [DATA_W-1:0] merge_sum;
  logic              merge_valid, merge_last;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MATRIX_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_MATRIX_SIZE) begin
      prdata = PDATA_W'(matrix_size_q);
    end
  end

  always_comb begin
    if (matrix_size_q == '0) begin
      nm1 = '0;
    end else if (32'(matrix_size_q) > MAX_SIZE) begin
      nm1 = IDX_W'(MAX_SIZE - 1);
    end else begin
      nm1 = IDX_W'(matrix_size_q - 1'b1);
    end
  end

  // Handshakes
  assign in_i.ready = (state_q == ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;
  assign adv        = !out_valid_q || out_o.ready;
  assign issue      = issuing_q && adv;
  assign load_done  = in_acc && (row_q == nm1) && (col_q == nm1);
  assign issue_last = (oi_q == nm1) && (oj_q == nm1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (load_done) begin
          state_d = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        if (out_acc && out_last_q) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= SIZE_RESET;
      row_q         <= '0;
      col_q         <= '0;
    end else if (cfg_we) begin
      matrix_size_q <= pwdata[SIZE_W-1:0];
      row_q         <= '0;
      col_q         <= '0;
    end else if (in_acc) begin
      if (col_q == nm1) begin
        col_q <= '0;
        row_q <= (row_q == nm1) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Issue read addresses for each product element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      oi_q      <= '0;
      oj_q      <= '0;
    end else if (load_done) begin
      issuing_q <= 1'b1;
      oi_q      <= '0;
      oj_q      <= '0;
    end else if (issue) begin
      if (issue_last) begin
        issuing_q <= 1'b0;
      end
      if (oj_q == nm1) begin
        oj_q <= '0;
        oi_q <= oi_q + 1'b1;
      end else begin
        oj_q <= oj_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      l1_q <= 1'b0;
      v2_q <= 1'b0;
      l2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      l1_q <= issue && issue_last;
      v2_q <= v1_q;
      l2_q <= l1_q;
    end
  end

  // Lanes
  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_lane
    always_comb begin
      lane_ctl[k].wr_a   = in_acc && (col_q == IDX_W'(k));
      lane_ctl[k].wr_b   = in_acc && (row_q == IDX_W'(k));
      lane_ctl[k].rd     = adv;
      lane_ctl[k].active = (IDX_W'(k) <= nm1);
    end

    smm_lane #(.MAX_SIZE(MAX_SIZE)) u_lane (
      .clk_i       (clk_i),
      .ctl_i       (lane_ctl[k]),
      .wr_addr_a_i (row_q),
      .wr_addr_b_i (col_q),
      .wr_data_a_i (in_i.a_elem),
      .wr_data_b_i (in_i.b_elem),
      .rd_addr_a_i (oi_q),
      .rd_addr_b_i (oj_q),
      .prod_o      (lane_prod[k])
    );
  end

  smm_merge #(.LANES(MAX_SIZE)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .last_i  (l2_q),
    .val_i   (lane_prod),
    .sum_o   (merge_sum),
    .valid_o (merge_valid),
    .last_o  (merge_last)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= merge_valid;
      out_last_q  <= merge_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= merge_sum;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = out_data_q;
  assign out_o.last_of_run   = out_last_q;

`ifndef ASSERT_OFF
  a_load_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !out_valid_q && !v1_q && !v2_q && !merge_valid)
    else $error("pipeline busy while loading");

  a_issue_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> state_q == ST_COMPUTE)
    else $error("issuing outside compute");

  a_last_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> !issuing_q)
    else $error("last element emitted before issue finished");

  a_load_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> row_q <= nm1 && col_q <= nm1)
    else $error("load position beyond matrix size");

  a_enter_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_done |=> issuing_q && oi_q == '0 && oj_q == '0)
    else $error("compute did not start after load");
`endif

endmodule

// ===== verif/square_matrix_multiply_unit_test.sv =====
// Self-checking testbench for square_matrix_multiply_unit: drives element pairs and
// matrix_size writes, and predicts every product element in row-major order.
// Depends on smm_pkg, smm_in_if, smm_out_if and the unit itself.
module square_matrix_multiply_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smm_pkg::*;

  localparam int unsigned MAX_N         = 8;
  localparam int unsigned REG_UNMAPPED  = 1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } elem_pair_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } product_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  square_matrix_multiply_unit #(.MAX_SIZE(MAX_N)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  elem_pair_t        pending_q[$];
  product_t          product_q[$];
  logic [DATA_W-1:0] a_store[MAX_N*MAX_N];
  logic [DATA_W-1:0] b_store[MAX_N*MAX_N];
  int unsigned       fill_count;
  logic [SIZE_W-1:0] size_reg;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       error_count;
  int unsigned       cycle_count;
  logic              in_fire;

  function automatic int unsigned eff_dim(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_N) return MAX_N;
    return 32'(s);
  endfunction

  function automatic logic [DATA_W-1:0] pick_elem();
    if ($urandom_range(7) != 0) return $urandom();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return 32'd1;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    if (error_count < REPORT_MAX)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    error_count++;
  endtask

  task automatic accumulate_item(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    int unsigned       n;
    int unsigned       total;
    int unsigned       pos;
    logic [DATA_W-1:0] acc;
    product_t          p;
    n     = eff_dim(size_reg);
    total = n * n;
    pos   = fill_count;
    if (pos >= total) pos = 0;
    a_store[pos] = a;
    b_store[pos] = b;
    pos++;
    if (pos < total) begin
      fill_count = pos;
    end else begin
      fill_count = 0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j < n; j++) begin
          acc = '0;
          for (int unsigned k = 0; k < n; k++)
            acc = acc + a_store[i*n+k] * b_store[k*n+j];
          p.value = acc;
          p.last  = (i == n - 1) && (j == n - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.a_elem  = '0;
    in_ch.b_elem  = '0;
    out_ch.ready  = 1'b0;
    in_fire       = 1'b0;
    cycle_count   = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid  <= 1'b1;
        in_ch.a_elem <= pending_q[0].a;
        in_ch.b_elem <= pending_q[0].b;
        pending_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready)
      accumulate_item(in_ch.a_elem, in_ch.b_elem);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (product_q.size() == 0) begin
        note_mismatch("unexpected product", '0, out_ch.product_value);
      end else begin
        if (out_ch.product_value !== product_q[0].value)
          note_mismatch("product_value", product_q[0].value, out_ch.product_value);
        if (out_ch.last_of_run !== product_q[0].last)
          note_mismatch("last_of_run", DATA_W'(product_q[0].last), DATA_W'(out_ch.last_of_run));
        product_q.pop_front();
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || product_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input int unsigned idx,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'(idx << 2);
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr && idx == REG_MATRIX_SIZE) begin
      size_reg   = wdata[SIZE_W-1:0];
      fill_count = 0;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_size_readback();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, REG_MATRIX_SIZE, '0, rd);
    if (rd !== PDATA_W'(size_reg))
      note_mismatch("matrix_size readback", PDATA_W'(size_reg), rd);
  endtask

  task automatic set_register(input int unsigned idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, idx, value, rd);
    check_size_readback();
  endtask

  task automatic push_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    elem_pair_t e;
    e.a = a;
    e.b = b;
    pending_q.push_back(e);
  endtask

  task automatic push_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      push_pair(pick_elem(), pick_elem());
  endtask

  initial begin
    int unsigned       mode_items;
    int unsigned       n;
    logic [SIZE_W-1:0] sz;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    fill_count     = 0;
    size_reg       = SIZE_RESET;
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_size_readback();

    set_register(REG_MATRIX_SIZE, 0);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7fff_ffff, 32'h7fff_ffff);
    push_pair('1, 32'h8000_0000);
    push_pair('0, 32'h7fff_ffff);

    set_register(REG_MATRIX_SIZE, 2);
    push_pair(32'h7fff_ffff, 32'h8000_0000);
    push_pair(32'h8000_0000, '1);
    push_pair('1, 32'h7fff_ffff);
    set_register(REG_UNMAPPED, 3);
    push_pair(32'd1, '1);

    push_random(2);
    set_register(REG_MATRIX_SIZE, 3);
    push_random(9);

    for (int unsigned mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (mode == 0) begin
        set_register(REG_MATRIX_SIZE, 15);
        push_random(MAX_N * MAX_N);
      end
      mode_items = 0;
      while (mode_items < 8) begin
        sz = SIZE_W'($urandom_range(5));
        n  = eff_dim(sz);
        set_register(REG_MATRIX_SIZE, PDATA_W'(sz));
        repeat ($urandom_range(1, 3)) begin
          push_random(n * n);
          mode_items += n * n;
        end
        if (n > 1 && $urandom_range(3) == 0)
          push_random($urandom_range(1, n * n - 1));
      end
    end

    wait_idle();
    if (error_count == 0 && product_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/smm_pkg.sv
hw/rtl/smm_in_if.sv
hw/rtl/smm_out_if.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_lane.sv
hw/rtl/smm_merge.sv
hw/rtl/square_matrix_multiply_unit.sv
verif/square_matrix_multiply_unit_test.sv
